>>> hw/rtl/line_follower_controller_defines.svh
// ----------------------------------------------------------------------------
// Line follower controller - assertion macros
// Shared macros for the concurrent checks in the controller RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_CONTROLLER_DEFINES_SVH
`define LINE_FOLLOWER_CONTROLLER_DEFINES_SVH

// Overlapping implication, checked on every rising edge outside reset
`define LFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define LFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower controller package
// Phase codes, sensor patterns, register map and configuration type.
// ----------------------------------------------------------------------------
package lfc_pkg;

  // Controller phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CRUISE  = 3'd1,
    PH_STEER_L = 3'd2,
    PH_STEER_R = 3'd3,
    PH_JPASS   = 3'd4,
    PH_SPIN    = 3'd5,
    PH_DONE    = 3'd6
  } phase_e;

  // Sensor patterns (left, middle, right; 1 is white)
  localparam logic [2:0] SNS_ALL_BLACK = 3'b000;
  localparam logic [2:0] SNS_RIGHT     = 3'b001;
  localparam logic [2:0] SNS_CENTER    = 3'b010;
  localparam logic [2:0] SNS_STEER_R   = 3'b011;
  localparam logic [2:0] SNS_LEFT      = 3'b100;
  localparam logic [2:0] SNS_STEER_L   = 3'b110;
  localparam logic [2:0] SNS_JUNCTION  = 3'b111;

  // Last white side codes
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // Register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_DROP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_JUNC_TARGET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT  = 3'd6;

  // Register reset values
  localparam logic [6:0]  RST_CRUISE      = 7'd126;
  localparam logic [6:0]  RST_STEER_DROP  = 7'd40;
  localparam logic [6:0]  RST_RECOVERY    = 7'd50;
  localparam logic [6:0]  RST_SPIN        = 7'd64;
  localparam logic [7:0]  RST_JUNC_TARGET = 8'd1;
  localparam logic [15:0] RST_TIME_LIMIT  = 16'd1000;

  localparam logic [7:0] JCNT_MAX = 8'd255;

  // Configuration bundle
  typedef struct packed {
    logic        run_mode;
    logic [6:0]  cruise_speed;
    logic [6:0]  steer_drop;
    logic [6:0]  recovery_speed;
    logic [6:0]  spin_speed;
    logic [7:0]  junction_target;
    logic [15:0] time_limit_ms;
  } cfg_t;

endpackage

>>> hw/rtl/lfc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower controller - configuration registers
// Indexed write port into the run settings; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lfc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lfc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output lfc_pkg::cfg_t                    cfg_o
);

  lfc_pkg::cfg_t cfg_q, cfg_d;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lfc_pkg::CFG_RUN_MODE:    cfg_d.run_mode        = cfg_data_i[0];
        lfc_pkg::CFG_CRUISE:      cfg_d.cruise_speed    = cfg_data_i[6:0];
        lfc_pkg::CFG_STEER_DROP:  cfg_d.steer_drop      = cfg_data_i[6:0];
        lfc_pkg::CFG_RECOVERY:    cfg_d.recovery_speed  = cfg_data_i[6:0];
        lfc_pkg::CFG_SPIN:        cfg_d.spin_speed      = cfg_data_i[6:0];
        lfc_pkg::CFG_JUNC_TARGET: cfg_d.junction_target = cfg_data_i[7:0];
        lfc_pkg::CFG_TIME_LIMIT:  cfg_d.time_limit_ms   = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_mode        <= 1'b0;
      cfg_q.cruise_speed    <= lfc_pkg::RST_CRUISE;
      cfg_q.steer_drop      <= lfc_pkg::RST_STEER_DROP;
      cfg_q.recovery_speed  <= lfc_pkg::RST_RECOVERY;
      cfg_q.spin_speed      <= lfc_pkg::RST_SPIN;
      cfg_q.junction_target <= lfc_pkg::RST_JUNC_TARGET;
      cfg_q.time_limit_ms   <= lfc_pkg::RST_TIME_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/line_follower_controller.sv
`timescale 1ns / 1ps
// The sample register takes an accepted sample transaction; the state update then
//   loads the result register from it.
// Throughput: one sample per cycle while the result channel is not stalled.
// Reset: asynchronous, active low; phase idle, drives zero, counters cleared,
//   run settings at their defaults. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
// Line follower controller
// Three-sensor line follower: steering, line recovery, junction and time stops.
// ----------------------------------------------------------------------------
`include "line_follower_controller_defines.svh"

module line_follower_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           start_req_i,
  input  logic [2:0]                     sensors_i,
  input  logic [31:0]                    time_ms_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [7:0]              left_drive_o,
  output logic signed [7:0]              right_drive_o,
  output logic                           done_res_o,
  output logic                           unexpected_o
);

  lfc_pkg::cfg_t cfg;

  // Configuration registers
  lfc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Sample register
  // --------------------------------------------------------------------------
  logic        s1_valid_q;
  logic        s1_start_q;
  logic [2:0]  s1_sns_q;
  logic [31:0] s1_time_q;
  logic        s1_adv;
  logic        out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_start_q <= start_req_i;
      s1_sns_q   <= sensors_i;
      s1_time_q  <= time_ms_i;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  lfc_pkg::phase_e   phase_q, phase_d, phase_cur;
  logic [7:0]        jcnt_q, jcnt_d, jcnt_cur, jcnt_inc;
  logic [1:0]        side_q, side_d;
  logic [31:0]       tstart_q, tstart_d, tstart_cur;
  logic signed [7:0] left_q, left_d, left_cur;
  logic signed [7:0] right_q, right_d, right_cur;
  logic              unexp_q, unexp_d;

  // Start request overrides the stored run state
  assign phase_cur  = s1_start_q ? lfc_pkg::PH_CRUISE : phase_q;
  assign jcnt_cur   = s1_start_q ? 8'd0 : jcnt_q;
  assign tstart_cur = s1_start_q ? s1_time_q : tstart_q;
  assign left_cur   = s1_start_q ? $signed({1'b0, cfg.cruise_speed}) : left_q;
  assign right_cur  = s1_start_q ? $signed({1'b0, cfg.cruise_speed}) : right_q;

  // Shared decode
  logic [31:0]       elapsed;
  logic              time_up;
  logic              junc_hit;
  logic signed [7:0] cruise_drv, inner_drv, spin_drv, recov_drv;

  assign elapsed    = s1_time_q - tstart_cur;
  assign time_up    = cfg.run_mode && (elapsed >= {16'd0, cfg.time_limit_ms});
  assign jcnt_inc   = (jcnt_cur < lfc_pkg::JCNT_MAX) ? jcnt_cur + 8'd1 : jcnt_cur;
  assign junc_hit   = (jcnt_inc == cfg.junction_target);
  assign cruise_drv = $signed({1'b0, cfg.cruise_speed});
  assign inner_drv  = (cfg.cruise_speed > cfg.steer_drop) ?
                      $signed({1'b0, cfg.cruise_speed - cfg.steer_drop}) : 8'sd0;
  assign spin_drv   = $signed({1'b0, cfg.spin_speed});
  assign recov_drv  = $signed({1'b0, cfg.recovery_speed});

  // Next phase
  always_comb begin
    phase_d = phase_cur;
    case (phase_cur)
      lfc_pkg::PH_CRUISE: begin
        if (time_up) begin
          phase_d = lfc_pkg::PH_DONE;
        end else begin
          case (s1_sns_q)
            lfc_pkg::SNS_STEER_L:   phase_d = lfc_pkg::PH_STEER_L;
            lfc_pkg::SNS_STEER_R:   phase_d = lfc_pkg::PH_STEER_R;
            lfc_pkg::SNS_ALL_BLACK: phase_d = lfc_pkg::PH_SPIN;
            lfc_pkg::SNS_JUNCTION: begin
              if (!cfg.run_mode) begin
                phase_d = junc_hit ? lfc_pkg::PH_DONE : lfc_pkg::PH_JPASS;
              end
            end
            default: ;
          endcase
        end
      end
      lfc_pkg::PH_STEER_L: begin
        if (s1_sns_q != lfc_pkg::SNS_STEER_L) phase_d = lfc_pkg::PH_CRUISE;
      end
      lfc_pkg::PH_STEER_R: begin
        if (s1_sns_q != lfc_pkg::SNS_STEER_R) phase_d = lfc_pkg::PH_CRUISE;
      end
      lfc_pkg::PH_JPASS: begin
        if (s1_sns_q != lfc_pkg::SNS_JUNCTION) phase_d = lfc_pkg::PH_CRUISE;
      end
      lfc_pkg::PH_SPIN: begin
        if (s1_sns_q == lfc_pkg::SNS_CENTER) phase_d = lfc_pkg::PH_CRUISE;
      end
      lfc_pkg::PH_DONE: phase_d = lfc_pkg::PH_DONE;
      default:          phase_d = lfc_pkg::PH_IDLE;
    endcase
  end

  // Drives, counters and flags
  always_comb begin
    left_d   = left_cur;
    right_d  = right_cur;
    jcnt_d   = jcnt_cur;
    side_d   = side_q;
    tstart_d = tstart_cur;
    unexp_d  = 1'b0;
    case (phase_cur)
      lfc_pkg::PH_CRUISE: begin
        if (time_up) begin
          left_d  = 8'sd0;
          right_d = 8'sd0;
        end else begin
          case (s1_sns_q)
            lfc_pkg::SNS_CENTER: ;
            lfc_pkg::SNS_STEER_L: begin
              left_d  = inner_drv;
              right_d = cruise_drv;
            end
            lfc_pkg::SNS_STEER_R: begin
              left_d  = cruise_drv;
              right_d = inner_drv;
            end
            lfc_pkg::SNS_LEFT:  side_d = lfc_pkg::SIDE_LEFT;
            lfc_pkg::SNS_RIGHT: side_d = lfc_pkg::SIDE_RIGHT;
            lfc_pkg::SNS_ALL_BLACK: begin
              // spin away from the side that last went white
              if (side_q == lfc_pkg::SIDE_LEFT) begin
                left_d  = spin_drv;
                right_d = -spin_drv;
              end else begin
                left_d  = -spin_drv;
                right_d = spin_drv;
              end
            end
            lfc_pkg::SNS_JUNCTION: begin
              if (!cfg.run_mode) begin
                jcnt_d = jcnt_inc;
                if (junc_hit) begin
                  left_d  = 8'sd0;
                  right_d = 8'sd0;
                end
              end
            end
            default: begin
              // 101: stop motors and flag it
              left_d  = 8'sd0;
              right_d = 8'sd0;
              unexp_d = 1'b1;
            end
          endcase
        end
      end
      lfc_pkg::PH_STEER_L: begin
        if (s1_sns_q != lfc_pkg::SNS_STEER_L) begin
          left_d  = cruise_drv;
          right_d = cruise_drv;
        end
      end
      lfc_pkg::PH_STEER_R: begin
        if (s1_sns_q != lfc_pkg::SNS_STEER_R) begin
          left_d  = cruise_drv;
          right_d = cruise_drv;
        end
      end
      lfc_pkg::PH_JPASS: ;
      lfc_pkg::PH_SPIN: begin
        if (s1_sns_q == lfc_pkg::SNS_CENTER) begin
          left_d  = recov_drv;
          right_d = recov_drv;
        end
      end
      default: begin
        left_d  = 8'sd0;
        right_d = 8'sd0;
      end
    endcase
  end

  // State and result registers, loaded as the sample leaves its register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= lfc_pkg::PH_IDLE;
      jcnt_q   <= 8'd0;
      side_q   <= lfc_pkg::SIDE_NONE;
      tstart_q <= 32'd0;
      left_q   <= 8'sd0;
      right_q  <= 8'sd0;
      unexp_q  <= 1'b0;
    end else if (s1_adv) begin
      phase_q  <= phase_d;
      jcnt_q   <= jcnt_d;
      side_q   <= side_d;
      tstart_q <= tstart_d;
      left_q   <= left_d;
      right_q  <= right_d;
      unexp_q  <= unexp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Result outputs
  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign done_res_o    = (phase_q == lfc_pkg::PH_DONE);
  assign unexpected_o  = unexp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LFC_ASSERT_IMPL(a_done_stopped, clk_i, rst_ni, out_valid_q && done_res_o,
    left_q == 8'sd0 && right_q == 8'sd0, "done result with motors running")
  `LFC_ASSERT_IMPL(a_unexp_stopped, clk_i, rst_ni, out_valid_q && unexp_q,
    left_q == 8'sd0 && right_q == 8'sd0 && phase_q == lfc_pkg::PH_CRUISE,
    "unexpected flag without stop in cruise")
  `LFC_ASSERT_NEXT(a_sample_captured, clk_i, rst_ni, in_valid_i && in_ready_o,
    s1_valid_q, "accepted sample transaction lost")
  `LFC_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, s1_adv, out_valid_q,
    "state updated without a result")

endmodule

>>> test/line_follower_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower controller testbench
// Drives sensor samples through a valid/ready port, with random gaps on the
// sample side and random stalls on the drive side. Each sample transaction is
// run through a local model of the controller, and every drive transaction is
// compared with the oldest expected result. A short fixed sequence covers
// each sensor pattern and the corner cases. A long junction run checks that
// the count saturates. Random phases follow, each under its own register
// settings.
// ----------------------------------------------------------------------------
module line_follower_controller_test;

  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned RAND_ITEMS  = 28;
  localparam int unsigned SAT_ITEMS   = 516;
  // pattern with both outer sensors white; no package constant for it
  localparam logic [2:0]  SNS_SPLIT   = 3'b101;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              done_res;
    logic              unexpected;
  } drive_res_t;

  typedef struct packed {
    logic       start_req;
    logic [2:0] sensors;
    logic [31:0] time_ms;
    logic       fixed;     // expected result is given in the row
    drive_res_t res;
  } sample_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [lfc_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           start_req_i;
  logic [2:0]                     sensors_i;
  logic [31:0]                    time_ms_i;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic signed [7:0]              left_drive_o;
  logic signed [7:0]              right_drive_o;
  logic                           done_res_o;
  logic                           unexpected_o;

  // Model state and register copy
  lfc_pkg::cfg_t     ctl_cfg;
  lfc_pkg::phase_e   ctl_phase;
  logic [7:0]        junc_count;
  logic [1:0]        white_side;
  logic [31:0]       run_t0;
  logic signed [7:0] hold_left;
  logic signed [7:0] hold_right;

  drive_res_t  drive_q[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  logic        quiet       = 1'b0;  // no gaps or stalls while set

  line_follower_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_req_i   (start_req_i),
    .sensors_i     (sensors_i),
    .time_ms_i     (time_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .done_res_o    (done_res_o),
    .unexpected_o  (unexpected_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive side back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(0, 99) >= 20);
  end

  // Compare each drive transaction with the oldest expectation
  always @(posedge clk_i) begin
    drive_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_q.size() == 0) begin
        $error("drive transaction with no expected result");
        fail_count++;
      end else begin
        exp_res = drive_q.pop_front();
        if (left_drive_o !== exp_res.left_drive) begin
          $error("left_drive: expected %0d, actual %0d", exp_res.left_drive, left_drive_o);
          fail_count++;
        end
        if (right_drive_o !== exp_res.right_drive) begin
          $error("right_drive: expected %0d, actual %0d", exp_res.right_drive,
                 right_drive_o);
          fail_count++;
        end
        if (done_res_o !== exp_res.done_res) begin
          $error("done_res: expected %0b, actual %0b", exp_res.done_res, done_res_o);
          fail_count++;
        end
        if (unexpected_o !== exp_res.unexpected) begin
          $error("unexpected: expected %0b, actual %0b", exp_res.unexpected,
                 unexpected_o);
          fail_count++;
        end
      end
    end
  end

  // Next controller state and drives for one sample
  task automatic advance_controller(input logic start_req, input logic [2:0] sensors,
                                    input logic [31:0] time_ms, output drive_res_t res);
    logic [31:0] elapsed;
    logic [6:0]  inner;
    inner = (ctl_cfg.cruise_speed > ctl_cfg.steer_drop) ?
            ctl_cfg.cruise_speed - ctl_cfg.steer_drop : 7'd0;
    res = '0;
    if (start_req) begin
      junc_count = '0;
      run_t0     = time_ms;
      hold_left  = {1'b0, ctl_cfg.cruise_speed};
      hold_right = {1'b0, ctl_cfg.cruise_speed};
      ctl_phase  = lfc_pkg::PH_CRUISE;
    end
    elapsed = time_ms - run_t0;
    case (ctl_phase)
      lfc_pkg::PH_CRUISE: begin
        if (ctl_cfg.run_mode && elapsed >= {16'd0, ctl_cfg.time_limit_ms}) begin
          hold_left  = '0;
          hold_right = '0;
          ctl_phase  = lfc_pkg::PH_DONE;
        end else begin
          case (sensors)
            lfc_pkg::SNS_CENTER: ;
            lfc_pkg::SNS_STEER_L: begin
              hold_left  = {1'b0, inner};
              hold_right = {1'b0, ctl_cfg.cruise_speed};
              ctl_phase  = lfc_pkg::PH_STEER_L;
            end
            lfc_pkg::SNS_STEER_R: begin
              hold_left  = {1'b0, ctl_cfg.cruise_speed};
              hold_right = {1'b0, inner};
              ctl_phase  = lfc_pkg::PH_STEER_R;
            end
            lfc_pkg::SNS_LEFT:  white_side = lfc_pkg::SIDE_LEFT;
            lfc_pkg::SNS_RIGHT: white_side = lfc_pkg::SIDE_RIGHT;
            lfc_pkg::SNS_ALL_BLACK: begin
              // spin away from the side that went white last
              if (white_side == lfc_pkg::SIDE_LEFT) begin
                hold_left  = {1'b0, ctl_cfg.spin_speed};
                hold_right = 8'sd0 - {1'b0, ctl_cfg.spin_speed};
              end else begin
                hold_left  = 8'sd0 - {1'b0, ctl_cfg.spin_speed};
                hold_right = {1'b0, ctl_cfg.spin_speed};
              end
              ctl_phase = lfc_pkg::PH_SPIN;
            end
            lfc_pkg::SNS_JUNCTION: begin
              if (!ctl_cfg.run_mode) begin
                if (junc_count != lfc_pkg::JCNT_MAX) junc_count++;
                if (junc_count == ctl_cfg.junction_target) begin
                  hold_left  = '0;
                  hold_right = '0;
                  ctl_phase  = lfc_pkg::PH_DONE;
                end else begin
                  ctl_phase = lfc_pkg::PH_JPASS;
                end
              end
            end
            default: begin
              hold_left      = '0;
              hold_right     = '0;
              res.unexpected = 1'b1;
            end
          endcase
        end
      end
      lfc_pkg::PH_STEER_L, lfc_pkg::PH_STEER_R: begin
        if (sensors != ((ctl_phase == lfc_pkg::PH_STEER_L) ? lfc_pkg::SNS_STEER_L
                                                             : lfc_pkg::SNS_STEER_R)) begin
          hold_left  = {1'b0, ctl_cfg.cruise_speed};
          hold_right = {1'b0, ctl_cfg.cruise_speed};
          ctl_phase  = lfc_pkg::PH_CRUISE;
        end
      end
      lfc_pkg::PH_JPASS: begin
        if (sensors != lfc_pkg::SNS_JUNCTION) ctl_phase = lfc_pkg::PH_CRUISE;
      end
      lfc_pkg::PH_SPIN: begin
        if (sensors == lfc_pkg::SNS_CENTER) begin
          hold_left  = {1'b0, ctl_cfg.recovery_speed};
          hold_right = {1'b0, ctl_cfg.recovery_speed};
          ctl_phase  = lfc_pkg::PH_CRUISE;
        end
      end
      lfc_pkg::PH_DONE: begin
        hold_left  = '0;
        hold_right = '0;
      end
      default: begin
        ctl_phase  = lfc_pkg::PH_IDLE;
        hold_left  = '0;
        hold_right = '0;
      end
    endcase
    res.left_drive  = hold_left;
    res.right_drive = hold_right;
    res.done_res    = (ctl_phase == lfc_pkg::PH_DONE);
  endtask

  // One sample transaction; called at a falling edge, returns at one
  task automatic send_sample(input logic start_req, input logic [2:0] sensors,
                             input logic [31:0] time_ms, input logic fixed,
                             input drive_res_t fixed_res);
    drive_res_t res;
    while (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= start_req;
    sensors_i   <= sensors;
    time_ms_i   <= time_ms;
    do @(posedge clk_i); while (!in_ready_o);
    advance_controller(start_req, sensors, time_ms, res);
    drive_q.push_back(fixed ? fixed_res : res);
    @(negedge clk_i);
  endtask

  // Write every register, then take the new settings into the model
  task automatic program_regs(input lfc_pkg::cfg_t cfg);
    logic [lfc_pkg::CFG_IDX_W-1:0]  reg_idx [7];
    logic [lfc_pkg::CFG_DATA_W-1:0] reg_val [7];
    reg_idx[0] = lfc_pkg::CFG_RUN_MODE;
    reg_val[0] = lfc_pkg::CFG_DATA_W'(cfg.run_mode);
    reg_idx[1] = lfc_pkg::CFG_CRUISE;
    reg_val[1] = lfc_pkg::CFG_DATA_W'(cfg.cruise_speed);
    reg_idx[2] = lfc_pkg::CFG_STEER_DROP;
    reg_val[2] = lfc_pkg::CFG_DATA_W'(cfg.steer_drop);
    reg_idx[3] = lfc_pkg::CFG_RECOVERY;
    reg_val[3] = lfc_pkg::CFG_DATA_W'(cfg.recovery_speed);
    reg_idx[4] = lfc_pkg::CFG_SPIN;
    reg_val[4] = lfc_pkg::CFG_DATA_W'(cfg.spin_speed);
    reg_idx[5] = lfc_pkg::CFG_JUNC_TARGET;
    reg_val[5] = lfc_pkg::CFG_DATA_W'(cfg.junction_target);
    reg_idx[6] = lfc_pkg::CFG_TIME_LIMIT;
    reg_val[6] = cfg.time_limit_ms;
    for (int i = 0; i < 7; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx[i];
      cfg_data_i  <= reg_val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    ctl_cfg = cfg;
  endtask

  // Wait for every expected drive transaction, plus the pipeline depth
  task automatic drain;
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic sample_row_t dir_row(int start_req, logic [2:0] sensors,
                                          logic [31:0] time_ms, int fixed,
                                          int left_drive, int right_drive,
                                          int done_res, int unexpected);
    sample_row_t row;
    row.start_req = 1'(start_req);
    row.sensors   = sensors;
    row.time_ms   = time_ms;
    row.fixed     = 1'(fixed);
    row.res       = '{8'(left_drive), 8'(right_drive), 1'(done_res), 1'(unexpected)};
    return row;
  endfunction

  function automatic logic [6:0] rand_speed;
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    sample_row_t   dir_rows[$];
    lfc_pkg::cfg_t cfg;
    logic          start_req;
    logic [2:0]    sensors;
    logic [31:0]   tnow;
    int unsigned   dt_max;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    start_req_i = 1'b0;
    sensors_i   = '0;
    time_ms_i   = '0;

    // Model matches the register defaults after reset
    ctl_cfg    = '{1'b0, lfc_pkg::RST_CRUISE, lfc_pkg::RST_STEER_DROP,
                   lfc_pkg::RST_RECOVERY, lfc_pkg::RST_SPIN,
                   lfc_pkg::RST_JUNC_TARGET, lfc_pkg::RST_TIME_LIMIT};
    ctl_phase  = lfc_pkg::PH_IDLE;
    junc_count = '0;
    white_side = lfc_pkg::SIDE_NONE;
    run_t0     = '0;
    hold_left  = '0;
    hold_right = '0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fixed sequence under default settings
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_CENTER,    0,   1, 0, 0, 0, 0));  // idle
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_JUNCTION,  1,   1, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(1, lfc_pkg::SNS_CENTER,    100, 1, 126, 126, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_STEER_L,   101, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_STEER_L,   102, 0, 0, 0, 0, 0));  // hold
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_CENTER,    103, 0, 0, 0, 0, 0));  // end
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_STEER_R,   104, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_RIGHT,     105, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_LEFT,      106, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_ALL_BLACK, 107, 0, 0, 0, 0, 0));  // spin R
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_ALL_BLACK, 108, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_CENTER,    109, 0, 0, 0, 0, 0));  // recovery
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_RIGHT,     110, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_ALL_BLACK, 111, 0, 0, 0, 0, 0));  // spin L
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_CENTER,    112, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, SNS_SPLIT,              113, 1, 0, 0, 0, 1));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_CENTER,    114, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_JUNCTION,  115, 1, 0, 0, 1, 0));  // target
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_CENTER,    116, 1, 0, 0, 1, 0));
    dir_rows.push_back(dir_row(1, lfc_pkg::SNS_JUNCTION,  32'hFFFF_FFFF, 1, 0, 0, 1, 0));
    dir_rows.push_back(dir_row(1, lfc_pkg::SNS_CENTER,    0,   1, 126, 126, 0, 0));
    dir_rows.push_back(dir_row(1, SNS_SPLIT,              5,   1, 0, 0, 0, 1));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_STEER_R,   6,   0, 0, 0, 0, 0));
    dir_rows.push_back(dir_row(0, lfc_pkg::SNS_STEER_R,   7,   0, 0, 0, 0, 0));
    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].start_req, dir_rows[i].sensors, dir_rows[i].time_ms,
                  dir_rows[i].fixed, dir_rows[i].res);
    end
    drain();

    // Zero target is never reached; long junction run saturates the count
    cfg = '{1'b0, 7'd0, 7'd0, 7'd0, 7'd0, 8'd0, 16'd0};
    program_regs(cfg);
    for (int k = 0; k < SAT_ITEMS; k++) begin
      sensors = (k % 2 == 1) ? lfc_pkg::SNS_JUNCTION : lfc_pkg::SNS_CENTER;
      send_sample(k == 0, sensors, $urandom(), 1'b0, '0);
    end
    drain();

    // Random phases, each with fresh settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      cfg.run_mode        = 1'($urandom_range(0, 1));
      cfg.cruise_speed    = rand_speed();
      cfg.steer_drop      = rand_speed();
      cfg.recovery_speed  = rand_speed();
      cfg.spin_speed      = rand_speed();
      cfg.junction_target = 8'($urandom_range(1, 6));
      cfg.time_limit_ms   = 16'($urandom_range(1, 400));
      if (p == 0) cfg = '{1'b1, 7'd127, 7'd127, 7'd127, 7'd127, 8'd255, 16'hFFFF};
      if (p == 1) begin
        cfg.run_mode      = 1'b1;
        cfg.time_limit_ms = '0;
      end
      quiet = (p == 3);
      program_regs(cfg);

      dt_max = (cfg.time_limit_ms >> 4) + 3;
      tnow   = (p % 3 == 0) ? 32'hFFFF_FF00 : $urandom();
      for (int k = 0; k < RAND_ITEMS; k++) begin
        start_req = (k == 0) ||
                    ($urandom_range(0, 99) < ((ctl_phase == lfc_pkg::PH_DONE) ? 40 : 3));
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: sensors = lfc_pkg::SNS_CENTER;
          7, 8:                sensors = lfc_pkg::SNS_STEER_L;
          9, 10:               sensors = lfc_pkg::SNS_STEER_R;
          11:                  sensors = lfc_pkg::SNS_LEFT;
          12:                  sensors = lfc_pkg::SNS_RIGHT;
          13, 14:              sensors = lfc_pkg::SNS_ALL_BLACK;
          15, 16:              sensors = lfc_pkg::SNS_JUNCTION;
          17:                  sensors = SNS_SPLIT;
          default:             sensors = 3'($urandom_range(0, 7));
        endcase
        if ($urandom_range(0, 19) == 0) tnow = $urandom();
        else tnow = tnow + $urandom_range(0, dt_max);
        send_sample(start_req, sensors, tnow, 1'b0, '0);
      end
      drain();
    end
    quiet = 1'b0;

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
